@@ rtl/core/vra_pkg.sv @@
// ----------------------------------------------------------------------------
// vra_pkg: shared types and constants of the voice allocator
// Command and status bundles between the controller and the datapath, MIDI
// message kinds and the sizes of the voice store.
// ----------------------------------------------------------------------------
`default_nettype none

package vra_pkg;

    // voice store
    localparam int SLOTS  = 15;
    localparam int VOICES = 15;
    localparam int IDX_W  = 4;

    // MIDI message kinds (upper nibble of the status byte)
    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_PITCH    = 4'hE;
    localparam logic [3:0] KIND_SYSTEM   = 4'hF;

    // scan index operations
    typedef logic [2:0] idx_op_t;
    localparam idx_op_t IDX_HOLD     = 3'd0;
    localparam idx_op_t IDX_NEXT     = 3'd1;
    localparam idx_op_t IDX_PREV     = 3'd2;
    localparam idx_op_t IDX_INC      = 3'd3;
    localparam idx_op_t IDX_PTR      = 3'd4;
    localparam idx_op_t IDX_PTR_NEXT = 3'd5;
    localparam idx_op_t IDX_ZERO     = 3'd6;
    localparam idx_op_t IDX_NVC      = 3'd7;

    // result word selection
    typedef logic [2:0] emit_sel_t;
    localparam emit_sel_t EMIT_ON        = 3'd0;
    localparam emit_sel_t EMIT_STEAL_OFF = 3'd1;
    localparam emit_sel_t EMIT_MATCH_OFF = 3'd2;
    localparam emit_sel_t EMIT_PITCH     = 3'd3;
    localparam emit_sel_t EMIT_PASS      = 3'd4;
    localparam emit_sel_t EMIT_RELEASE   = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic      load;
        idx_op_t   idx_op;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      emit;
        emit_sel_t emit_sel;
        logic      emit_last;
        logic      note_write;
        logic      note_clear;
        logic      commit;
    } vra_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_op1;
        logic is_on;
        logic is_off;
        logic is_pitch;
        logic count_same;
        logic idx_busy;
        logic note_match;
        logic cnt_last;
        logic idx_last;
        logic idx_end;
        logic rel_last;
        logic out_free;
    } vra_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/midi_round_robin_voice_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// midi_round_robin_voice_allocator_unit: MPE round-robin voice allocator
// Spreads MIDI short messages over up to 15 voices on channels 2..16 with
// note stealing, pitch wheel fan-out and run-time voice count changes.
// ----------------------------------------------------------------------------
// One input word is taken while the controller is idle and is then worked
// alone: a decode step, then a scan of the busy flags at one voice per
// cycle, held while a result waits for room in the output register. A pitch
// wheel word gives one result per active voice. Results leave through an
// output register at most one per cycle. A new word may be accepted while
// the last result of the previous one still waits on m_ready. No clearing
// pass is needed after reset.
`default_nettype none

module midi_round_robin_voice_allocator_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_status_byte,
    input  wire logic [6:0]  s_data_one,
    input  wire logic [6:0]  s_data_two,
    input  wire logic [15:0] s_time_stamp,
    input  wire logic [3:0]  s_new_voice_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_status,
    output logic [6:0]       m_out_data_one,
    output logic [6:0]       m_out_data_two,
    output logic [15:0]      m_out_time_stamp,
    output logic             m_last
);
    import vra_pkg::*;

    vra_cmd_t  cmd;
    vra_stat_t stat;

    vra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vra_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_operation       (s_operation),
        .s_status_byte     (s_status_byte),
        .s_data_one        (s_data_one),
        .s_data_two        (s_data_two),
        .s_time_stamp      (s_time_stamp),
        .s_new_voice_count (s_new_voice_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_status      (m_out_status),
        .m_out_data_one    (m_out_data_one),
        .m_out_data_two    (m_out_data_two),
        .m_out_time_stamp  (m_out_time_stamp),
        .m_last            (m_last)
    );

    // a result word is only loaded when the output register can take it
    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded into a full output register");

    // an accepted word keeps the controller busy for its decode cycle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // a voice count commit ends the word and frees the input side
    a_commit_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> s_ready)
        else $error("controller busy after voice count commit");

    // a voice is never claimed and released in the same cycle
    a_note_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.note_write && (cmd.note_clear || cmd.commit)))
        else $error("conflicting voice store updates");

endmodule

`default_nettype wire

@@ rtl/core/vra_dp.sv @@
// ----------------------------------------------------------------------------
// vra_dp: voice allocator datapath
// Input word latch, voice store with busy flags, rotation pointer, voice
// count, scan index and counter, result word mux and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_dp (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire vra_pkg::vra_cmd_t    cmd,
    output vra_pkg::vra_stat_t        stat,
    input  wire logic                 s_operation,
    input  wire logic [7:0]           s_status_byte,
    input  wire logic [6:0]           s_data_one,
    input  wire logic [6:0]           s_data_two,
    input  wire logic [15:0]          s_time_stamp,
    input  wire logic [3:0]           s_new_voice_count,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_status,
    output logic [6:0]                m_out_data_one,
    output logic [6:0]                m_out_data_two,
    output logic [15:0]               m_out_time_stamp,
    output logic                      m_last
);
    import vra_pkg::*;

    // latched input word
    logic             op_reg;
    logic [7:0]       st_reg;
    logic [6:0]       d1_reg;
    logic [6:0]       d2_reg;
    logic [15:0]      ts_reg;
    logic [3:0]       nv_reg;

    // voice state
    logic [6:0]       note_mem [SLOTS];
    logic [SLOTS-1:0] busy_reg;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] active_reg;

    // scan
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] cnt_reg;

    // output register
    logic             m_valid_reg;
    logic [7:0]       ost_reg;
    logic [6:0]       od1_reg;
    logic [6:0]       od2_reg;
    logic [15:0]      ots_reg;
    logic             olast_reg;

    logic [3:0]       kind;
    logic [IDX_W-1:0] nvc;
    logic [IDX_W:0]   idx_plus;
    logic [IDX_W:0]   ptr_plus;
    logic [IDX_W-1:0] idx_rot_next;
    logic [IDX_W-1:0] idx_rot_prev;
    logic [IDX_W-1:0] ptr_rot_next;
    logic [IDX_W-1:0] chan;
    logic             idx_valid;
    logic [6:0]       note_rd;
    logic [SLOTS-1:0] above;
    logic [7:0]       pass_status;
    logic [7:0]       e_st;
    logic [6:0]       e_d1;
    logic [6:0]       e_d2;
    logic [15:0]      e_ts;

    // decode of the latched word
    assign kind = st_reg[7:4];
    assign nvc  = (nv_reg == 4'd0) ? IDX_W'(1) : nv_reg;
    assign pass_status = (kind == KIND_SYSTEM) ? st_reg : {kind, 4'h0};

    // rotation arithmetic
    assign idx_plus     = {1'b0, idx_reg} + 1'b1;
    assign ptr_plus     = {1'b0, ptr_reg} + 1'b1;
    assign idx_rot_next = (idx_plus >= {1'b0, active_reg}) ? '0 : idx_plus[IDX_W-1:0];
    assign ptr_rot_next = (ptr_plus >= {1'b0, active_reg}) ? '0 : ptr_plus[IDX_W-1:0];
    assign idx_rot_prev = (idx_reg == '0) ? active_reg - 1'b1 : idx_reg - 1'b1;
    assign chan         = idx_plus[IDX_W-1:0];

    // read of the voice at the scan index
    assign idx_valid = idx_reg < IDX_W'(SLOTS);
    assign note_rd   = idx_valid ? note_mem[idx_reg] : '0;

    // busy voices above the scan index and below the voice count
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            above[j] = busy_reg[j] && (IDX_W'(j) > idx_reg) && (IDX_W'(j) < active_reg);
        end
    end

    // status to the controller
    always_comb begin
        stat.is_op1     = op_reg;
        stat.is_on      = !op_reg && (kind == KIND_NOTE_ON) && (d2_reg != 7'd0);
        stat.is_off     = !op_reg && ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON));
        stat.is_pitch   = !op_reg && (kind == KIND_PITCH);
        stat.count_same = nvc == active_reg;
        stat.idx_busy   = idx_valid && busy_reg[idx_reg];
        stat.note_match = note_rd == d1_reg;
        stat.cnt_last   = cnt_reg == active_reg - 1'b1;
        stat.idx_last   = idx_reg == active_reg - 1'b1;
        stat.idx_end    = idx_reg >= active_reg;
        stat.rel_last   = ~|above;
        stat.out_free   = !m_valid_reg || m_ready;
    end

    // result word mux
    always_comb begin
        e_st = pass_status;
        e_d1 = d1_reg;
        e_d2 = d2_reg;
        e_ts = ts_reg;
        case (cmd.emit_sel)
            EMIT_ON:        e_st = {KIND_NOTE_ON, chan};
            EMIT_STEAL_OFF: begin
                e_st = {KIND_NOTE_OFF, chan};
                e_d1 = note_rd;
                e_d2 = '0;
            end
            EMIT_MATCH_OFF: e_st = {kind, chan};
            EMIT_PITCH:     e_st = {KIND_PITCH, chan};
            EMIT_PASS:      e_st = pass_status;
            EMIT_RELEASE:   begin
                e_st = {KIND_NOTE_OFF, chan};
                e_d1 = note_rd;
                e_d2 = '0;
                e_ts = '0;
            end
            default:        e_st = pass_status;
        endcase
    end

    // scan index next value
    always_comb begin
        case (cmd.idx_op)
            IDX_HOLD:     idx_next = idx_reg;
            IDX_NEXT:     idx_next = idx_rot_next;
            IDX_PREV:     idx_next = idx_rot_prev;
            IDX_INC:      idx_next = idx_plus[IDX_W-1:0];
            IDX_PTR:      idx_next = ptr_reg;
            IDX_PTR_NEXT: idx_next = ptr_rot_next;
            IDX_ZERO:     idx_next = '0;
            IDX_NVC:      idx_next = nvc;
            default:      idx_next = idx_reg;
        endcase
    end

    // input latch, scan registers, note store
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_operation;
            st_reg <= s_status_byte;
            d1_reg <= s_data_one;
            d2_reg <= s_data_two;
            ts_reg <= s_time_stamp;
            nv_reg <= s_new_voice_count;
        end
        idx_reg <= idx_next;
        if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.note_write) begin
            note_mem[idx_reg] <= d1_reg;
        end
    end

    // voice control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= '0;
            active_reg <= IDX_W'(VOICES);
            ptr_reg    <= IDX_W'(VOICES - 1);
        end else begin
            if (cmd.note_write) begin
                busy_reg[idx_reg] <= 1'b1;
                ptr_reg           <= idx_reg;
            end
            if (cmd.note_clear) begin
                busy_reg[idx_reg] <= 1'b0;
            end
            if (cmd.commit) begin
                active_reg <= nvc;
                ptr_reg    <= nvc - 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            ost_reg   <= e_st;
            od1_reg   <= e_d1;
            od2_reg   <= e_d2;
            ots_reg   <= e_ts;
            olast_reg <= cmd.emit_last;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_status     = ost_reg;
    assign m_out_data_one   = od1_reg;
    assign m_out_data_two   = od2_reg;
    assign m_out_time_stamp = ots_reg;
    assign m_last           = olast_reg;

endmodule

`default_nettype wire

@@ rtl/core/vra_ctrl.sv @@
// ----------------------------------------------------------------------------
// vra_ctrl: voice allocator controller
// Sequences decode, voice scans and result emission for one input word.
// ----------------------------------------------------------------------------
`default_nettype none

module vra_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire vra_pkg::vra_stat_t stat,
    output vra_pkg::vra_cmd_t       cmd
);
    import vra_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECODE   = 3'd1;
    localparam logic [2:0] ST_ON_SCAN  = 3'd2;
    localparam logic [2:0] ST_STEAL    = 3'd3;
    localparam logic [2:0] ST_ON_EMIT  = 3'd4;
    localparam logic [2:0] ST_OFF_SCAN = 3'd5;
    localparam logic [2:0] ST_PITCH    = 3'd6;
    localparam logic [2:0] ST_REL_PASS = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       rel_mode_reg, rel_mode_next;

    assign s_ready = state_reg == ST_IDLE;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        rel_mode_next = rel_mode_reg;
        cmd           = '0;
        cmd.idx_op    = IDX_HOLD;
        cmd.emit_sel  = EMIT_PASS;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_op1) begin
                    if (stat.count_same) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_op    = IDX_NVC;
                        rel_mode_next = 1'b1;
                        state_next    = ST_REL_PASS;
                    end
                end else if (stat.is_on) begin
                    cmd.idx_op  = IDX_PTR_NEXT;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_ON_SCAN;
                end else if (stat.is_off) begin
                    cmd.idx_op  = IDX_PTR;
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_OFF_SCAN;
                end else if (stat.is_pitch) begin
                    cmd.idx_op = IDX_ZERO;
                    state_next = ST_PITCH;
                end else begin
                    rel_mode_next = 1'b0;
                    state_next    = ST_REL_PASS;
                end
            end
            // look for a free voice after the pointer
            ST_ON_SCAN: begin
                if (!stat.idx_busy) begin
                    state_next = ST_ON_EMIT;
                end else if (stat.cnt_last) begin
                    cmd.idx_op = IDX_NEXT;
                    state_next = ST_STEAL;
                end else begin
                    cmd.idx_op  = IDX_NEXT;
                    cmd.cnt_inc = 1'b1;
                end
            end
            // all voices busy: release the stolen voice first
            ST_STEAL: begin
                if (stat.out_free) begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_STEAL_OFF;
                    state_next   = ST_ON_EMIT;
                end
            end
            ST_ON_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel   = EMIT_ON;
                    cmd.emit_last  = 1'b1;
                    cmd.note_write = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            // backward search from the pointer for the held note
            ST_OFF_SCAN: begin
                if (stat.idx_busy && stat.note_match) begin
                    if (stat.out_free) begin
                        cmd.emit       = 1'b1;
                        cmd.emit_sel   = EMIT_MATCH_OFF;
                        cmd.emit_last  = 1'b1;
                        cmd.note_clear = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (stat.cnt_last) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.idx_op  = IDX_PREV;
                    cmd.cnt_inc = 1'b1;
                end
            end
            // one pitch word per active voice
            ST_PITCH: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_PITCH;
                    cmd.emit_last = stat.idx_last;
                    if (stat.idx_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            // voice count release sweep, or a single passed-through word
            ST_REL_PASS: begin
                if (rel_mode_reg) begin
                    if (stat.idx_end) begin
                        cmd.commit = 1'b1;
                        state_next = ST_IDLE;
                    end else if (stat.idx_busy) begin
                        if (stat.out_free) begin
                            cmd.emit       = 1'b1;
                            cmd.emit_sel   = EMIT_RELEASE;
                            cmd.emit_last  = stat.rel_last;
                            cmd.note_clear = 1'b1;
                            cmd.idx_op     = IDX_INC;
                        end
                    end else begin
                        cmd.idx_op = IDX_INC;
                    end
                end else if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_sel  = EMIT_PASS;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rel_mode_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rel_mode_reg <= rel_mode_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_midi_round_robin_voice_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_midi_round_robin_voice_allocator_unit: self-checking bench of the allocator
// Drives MIDI words and voice count changes into the allocator, predicts the
// retagged, stolen, released and fanned-out words and checks every result word
// in order, under random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midi_round_robin_voice_allocator_unit;
    import vra_pkg::*;

    localparam logic       OP_MIDI       = 1'b0;
    localparam logic       OP_SET_VOICES = 1'b1;
    localparam logic [7:0] NO_NOTE       = 8'hFF;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic        op;
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [15:0] ts;
        logic [3:0]  nv;
    } midi_in_t;

    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  d1;
        logic [6:0]  d2;
        logic [15:0] ts;
        logic        last;
    } midi_out_t;

    // Tracks voice allocation and holds the words the allocator owes us
    class voice_allocation_tracker;
        logic [7:0] voice_note[SLOTS];
        int         rot_ptr;
        int         n_active;
        midi_out_t  expected_words[$];
        midi_out_t  batch[$];
        int         mismatches;

        function new();
            foreach (voice_note[i]) voice_note[i] = NO_NOTE;
            n_active   = VOICES;
            rot_ptr    = n_active - 1;
            mismatches = 0;
        endfunction

        task report(input string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        function void emit(logic [7:0] st, logic [6:0] d1, logic [6:0] d2, logic [15:0] ts);
            midi_out_t o;
            o.status = st;
            o.d1     = d1;
            o.d2     = d2;
            o.ts     = ts;
            o.last   = 1'b0;
            batch.push_back(o);
        endfunction

        // Predict the result words of one accepted input word
        function void take_input(midi_in_t w);
            logic [3:0] kind;
            int         nv;
            int         p;
            int         idx;
            bit         found;
            kind = w.status[7:4];
            batch.delete();
            if (w.op == OP_SET_VOICES) begin
                nv = (w.nv == 0) ? 1 : int'(w.nv);
                if (nv != n_active) begin
                    // release busy voices above the new count
                    for (int i = nv; i < n_active; i++) begin
                        if (voice_note[i] != NO_NOTE) begin
                            emit({KIND_NOTE_OFF, 4'(i + 1)}, voice_note[i][6:0], 7'd0, 16'd0);
                            voice_note[i] = NO_NOTE;
                        end
                    end
                    n_active = nv;
                    rot_ptr  = nv - 1;
                end
            end else if (kind == KIND_NOTE_ON && w.d2 != 0) begin
                // next free voice after the pointer, else steal the one after it
                p     = rot_ptr;
                found = 1'b0;
                for (int c = 0; c < n_active; c++) begin
                    p = (p + 1 >= n_active) ? 0 : p + 1;
                    if (voice_note[p] == NO_NOTE) begin
                        found = 1'b1;
                        break;
                    end
                end
                if (!found) begin
                    p = (p + 1 >= n_active) ? 0 : p + 1;
                    emit({KIND_NOTE_OFF, 4'(p + 1)}, voice_note[p][6:0], 7'd0, w.ts);
                end
                rot_ptr       = p;
                voice_note[p] = {1'b0, w.d1};
                emit({KIND_NOTE_ON, 4'(p + 1)}, w.d1, w.d2, w.ts);
            end else if (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON) begin
                // search backwards from the pointer for the holding voice
                for (int c = 0; c < n_active; c++) begin
                    idx = (rot_ptr + n_active - c) % n_active;
                    if (voice_note[idx] == {1'b0, w.d1}) begin
                        voice_note[idx] = NO_NOTE;
                        emit({kind, 4'(idx + 1)}, w.d1, w.d2, w.ts);
                        break;
                    end
                end
            end else if (kind == KIND_PITCH) begin
                for (int i = 0; i < n_active; i++)
                    emit({KIND_PITCH, 4'(i + 1)}, w.d1, w.d2, w.ts);
            end else if (kind == KIND_SYSTEM) begin
                emit(w.status, w.d1, w.d2, w.ts);
            end else begin
                emit({kind, 4'h0}, w.d1, w.d2, w.ts);
            end
            if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i]) expected_words.push_back(batch[i]);
        endfunction

        // Compare one result word with the oldest expected word
        task check_output(midi_out_t got);
            midi_out_t exp_w;
            if (expected_words.size() == 0) begin
                report($sformatf("unexpected word st=%h d1=%h d2=%h ts=%h last=%b",
                                 got.status, got.d1, got.d2, got.ts, got.last));
            end else begin
                exp_w = expected_words.pop_front();
                if (got.status !== exp_w.status || got.d1 !== exp_w.d1 ||
                    got.d2 !== exp_w.d2 || got.ts !== exp_w.ts || got.last !== exp_w.last)
                    report($sformatf({"got st=%h d1=%h d2=%h ts=%h last=%b, ",
                                      "want st=%h d1=%h d2=%h ts=%h last=%b"},
                                     got.status, got.d1, got.d2, got.ts, got.last,
                                     exp_w.status, exp_w.d1, exp_w.d2, exp_w.ts,
                                     exp_w.last));
            end
        endtask
    endclass

    logic        aclk              = 1'b0;
    logic        aresetn           = 1'b0;
    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic        s_operation       = 1'b0;
    logic [7:0]  s_status_byte     = 8'h00;
    logic [6:0]  s_data_one        = 7'h00;
    logic [6:0]  s_data_two        = 7'h00;
    logic [15:0] s_time_stamp      = 16'h0000;
    logic [3:0]  s_new_voice_count = 4'h1;
    logic        m_valid;
    logic        m_ready           = 1'b0;
    logic [7:0]  m_out_status;
    logic [6:0]  m_out_data_one;
    logic [6:0]  m_out_data_two;
    logic [15:0] m_out_time_stamp;
    logic        m_last;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles        = 0;

    voice_allocation_tracker sb;

    midi_round_robin_voice_allocator_unit i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_status_byte     (s_status_byte),
        .s_data_one        (s_data_one),
        .s_data_two        (s_data_two),
        .s_time_stamp      (s_time_stamp),
        .s_new_voice_count (s_new_voice_count),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_status      (m_out_status),
        .m_out_data_one    (m_out_data_one),
        .m_out_data_two    (m_out_data_two),
        .m_out_time_stamp  (m_out_time_stamp),
        .m_last            (m_last)
    );

    always #5 aclk = ~aclk;

    // Run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[midi_round_robin_voice_allocator_unit] ERROR");
            $finish;
        end
    end

    // Result side: check accepted words, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_output({m_out_status, m_out_data_one, m_out_data_two,
                             m_out_time_stamp, m_last});
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one input word, wait for the handshake, then maybe idle
    task automatic push_word(input logic op, input logic [7:0] st, input logic [6:0] d1,
                             input logic [6:0] d2, input logic [15:0] ts,
                             input logic [3:0] nv);
        midi_in_t w;
        w                 = {op, st, d1, d2, ts, nv};
        s_valid           <= 1'b1;
        s_operation       <= op;
        s_status_byte     <= st;
        s_data_one        <= d1;
        s_data_two        <= d2;
        s_time_stamp      <= ts;
        s_new_voice_count <= nv;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sb.take_input(w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_midi(input logic [7:0] st, input logic [6:0] d1,
                             input logic [6:0] d2, input logic [15:0] ts);
        push_word(OP_MIDI, st, d1, d2, ts, 4'($urandom_range(15)));
    endtask

    task automatic send_count(input logic [3:0] nv);
        push_word(OP_SET_VOICES, 8'($urandom), 7'($urandom), 7'($urandom),
                  16'($urandom), nv);
    endtask

    // Mostly note traffic with matching releases, some count changes and noise
    task automatic send_random(input int n);
        int         r;
        int         v;
        logic [3:0] kind;
        logic [6:0] note;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 40) begin
                send_midi({KIND_NOTE_ON, 4'($urandom_range(15))}, 7'($urandom),
                          7'($urandom_range(127, 1)), 16'($urandom));
            end else if (r < 65) begin
                v    = $urandom_range(sb.n_active - 1);
                note = (sb.voice_note[v] != NO_NOTE && $urandom_range(9) < 8) ?
                       sb.voice_note[v][6:0] : 7'($urandom);
                if ($urandom_range(3) == 0)
                    send_midi({KIND_NOTE_ON, 4'($urandom_range(15))}, note, 7'd0,
                              16'($urandom));
                else
                    send_midi({KIND_NOTE_OFF, 4'($urandom_range(15))}, note,
                              7'($urandom), 16'($urandom));
            end else if (r < 73) begin
                send_midi({KIND_PITCH, 4'($urandom_range(15))}, 7'($urandom),
                          7'($urandom), 16'($urandom));
            end else if (r < 80) begin
                r = $urandom_range(99);
                if (r < 60)      send_count(4'($urandom_range(4, 1)));
                else if (r < 85) send_count(4'($urandom_range(15, 5)));
                else if (r < 95) send_count(4'd15);
                else             send_count(4'd0);
            end else if (r < 90) begin
                // any kind other than note and pitch, including status below 0x80
                do kind = 4'($urandom_range(13));
                while (kind == KIND_NOTE_OFF || kind == KIND_NOTE_ON);
                send_midi({kind, 4'($urandom_range(15))}, 7'($urandom), 7'($urandom),
                          16'($urandom));
            end else if (r < 95) begin
                send_midi({KIND_SYSTEM, 4'($urandom_range(15))}, 7'($urandom),
                          7'($urandom), 16'($urandom));
            end else begin
                push_word(1'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                          16'($urandom), 4'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 11;
        recv_idle_pct = 79;

        // directed: fan-out on empty voices, allocation, retag, misses
        send_midi(8'hE0, 7'd0, 7'd127, 16'h0000);
        send_midi(8'h90, 7'd0, 7'd127, 16'hFFFF);
        send_midi(8'h9F, 7'd127, 7'd1, 16'h1234);
        send_midi(8'h80, 7'd127, 7'd64, 16'h0001);
        send_midi(8'h8F, 7'd55, 7'd0, 16'h8000);
        send_midi(8'h93, 7'd0, 7'd0, 16'h7FFF);
        // small voice count, stealing, unchanged count, count zero as one
        send_count(4'd3);
        send_midi(8'h90, 7'd10, 7'd100, 16'h0010);
        send_midi(8'h91, 7'd11, 7'd100, 16'h0011);
        send_midi(8'h92, 7'd12, 7'd100, 16'h0012);
        send_midi(8'h9C, 7'd13, 7'd100, 16'h0013);
        send_midi(8'hE7, 7'd127, 7'd0, 16'h0020);
        send_count(4'd3);
        send_count(4'd0);
        send_midi(8'h90, 7'd20, 7'd90, 16'h0030);
        send_count(4'd15);
        // other channel messages, low status, system pass-through
        send_midi(8'hB5, 7'd7, 7'd127, 16'h0040);
        send_midi(8'h00, 7'd127, 7'd127, 16'hFFFF);
        send_midi(8'h7F, 7'd0, 7'd0, 16'h0000);
        send_midi(8'hCA, 7'd5, 7'd0, 16'h0041);
        send_midi(8'hDF, 7'd64, 7'd0, 16'h0042);
        send_midi(8'hAF, 7'd60, 7'd33, 16'h0043);
        send_midi(8'hF0, 7'd1, 7'd2, 16'h0044);
        send_midi(8'hFF, 7'd127, 7'd127, 16'h0045);

        send_random(96);
        send_idle_pct = 79;
        recv_idle_pct = 11;
        send_random(95);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(95);
        s_valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("[midi_round_robin_voice_allocator_unit] OK");
        end else begin
            $display("[midi_round_robin_voice_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
